// ----- design/fet_pkg.sv -----
// shared operation codes, status codes and result limits for the extent allocator
package fet_pkg;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_LOW     = 3'd1,
    OP_AT_MOST = 3'd2,
    OP_MANY    = 3'd3,
    OP_HIGH    = 3'd4,
    OP_POP     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NF   = 2'd1,
    ST_FULL = 2'd2,
    ST_ZERO = 2'd3
  } status_t;

  localparam int RESULT_LIMIT = 64;
  localparam int RES_IW = $clog2(RESULT_LIMIT);
  localparam int RES_CW = $clog2(RESULT_LIMIT + 1);

endpackage

// ----- design/fet_ram.sv -----
// single write port, single registered read port memory
module fet_ram #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/free_extent_table_allocator.sv -----
// free extent table allocator: sorted extent table with first fit removal from either end and coalescing
// one word at a time; in_ready only in idle, no overlap between words
// run time grows with each table entry scanned or shifted and with each result word
// synchronous reset empties the table and drops any pending result
module free_extent_table_allocator
  import fet_pkg::*;
#(
  parameter int MAX_EXTENTS = 64,
  parameter int ADDR_BITS   = 44
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           operation,
  input  logic [ADDR_BITS-1:0] start_address,
  input  logic [ADDR_BITS:0]   amount,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_BITS-1:0] range_start,
  output logic [ADDR_BITS:0]   range_size,
  output logic [1:0]           status,
  output logic                 last,
  output logic [ADDR_BITS:0]   amount_taken,
  output logic [ADDR_BITS-1:0] low_address,
  output logic [ADDR_BITS:0]   high_end,
  output logic                 table_empty
);

  localparam int AB = ADDR_BITS;
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int EW = 2 * AB + 1;
  localparam int BW = AB + 2 * (AB + 1);
  localparam logic [AB:0] ADDR_LIMIT = (AB + 1)'(1) << AB;

  typedef enum logic [4:0] {
    S_IDLE, S_CLIP, S_IE, S_IRD, S_ICMP, S_IDEC, S_IB2,
    S_SHU, S_SHUW, S_SHD, S_SHDW,
    S_RRD, S_RCMP, S_RHI,
    S_TRD, S_TCMP, S_MCHK, S_PUSH,
    S_FIN, S_FLO, S_FHI, S_ERD, S_ELD, S_EWT
  } state_t;

  state_t state;
  logic [2:0]    op;
  logic [AB-1:0] s;
  logic [AB:0]   a, e, left, total;
  logic [CW-1:0] count, idx, pos, mk;
  logic [AB-1:0] prev_start, cur_start;
  logic [AB:0]   prev_size, cur_size;
  logic          curv, done;
  logic [AB-1:0] rs, lo;
  logic [AB:0]   rz, tk, hi;
  logic          emp;
  logic [1:0]    fstat;
  logic [RES_CW-1:0] nres, oidx;

  logic          t_we;
  logic [IW-1:0] t_waddr, t_raddr;
  logic [EW-1:0] t_wdata, t_rdata;
  logic [BW-1:0] b_rdata;

  logic [AB-1:0] rd_st;
  logic [AB:0]   rd_sz;
  logic [CW-1:0] jsel, pos_m1;
  logic          jp, jn, hit, exact, whole;

  assign rd_st  = t_rdata[EW-1:AB+1];
  assign rd_sz  = t_rdata[AB:0];
  assign pos_m1 = pos - 1'b1;
  assign jsel   = (op == OP_HIGH) ? CW'(count - 1'b1 - idx) : idx;
  assign jp     = (pos != '0) && ({1'b0, s} == ({1'b0, prev_start} + prev_size));
  assign jn     = curv && (e == {1'b0, cur_start});
  assign hit    = rd_sz >= a;
  assign exact  = rd_sz == a;
  assign whole  = (op == OP_POP) || (rd_sz <= left);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    t_raddr = '0;
    unique case (state)
      S_IRD: t_raddr = idx[IW-1:0];
      S_IDEC: begin
        if (jp && !jn) begin
          t_we    = 1'b1;
          t_waddr = pos_m1[IW-1:0];
          t_wdata = {prev_start, prev_size + a};
        end else if (jn && !jp) begin
          t_we    = 1'b1;
          t_waddr = pos[IW-1:0];
          t_wdata = {s, cur_size + a};
        end
      end
      S_IB2: begin
        t_we    = 1'b1;
        t_waddr = pos_m1[IW-1:0];
        t_wdata = {prev_start, prev_size + cur_size};
      end
      S_SHU: begin
        if (mk == pos) begin
          t_we    = 1'b1;
          t_waddr = pos[IW-1:0];
          t_wdata = {s, a};
        end else begin
          t_raddr = IW'(CW'(mk - 1'b1));
        end
      end
      S_SHUW, S_SHDW: begin
        t_we    = 1'b1;
        t_waddr = mk[IW-1:0];
        t_wdata = t_rdata;
      end
      S_SHD: t_raddr = IW'(CW'(mk + 1'b1));
      S_RRD: t_raddr = jsel[IW-1:0];
      S_RCMP: begin
        if (hit && !exact) begin
          t_we    = 1'b1;
          t_waddr = jsel[IW-1:0];
          if (op == OP_LOW) begin
            t_wdata = {rd_st + a[AB-1:0], rd_sz - a};
          end else begin
            t_wdata = {rd_st, rd_sz - a};
          end
        end
      end
      S_TCMP: begin
        if (!whole) begin
          t_we    = 1'b1;
          t_waddr = '0;
          t_wdata = {rd_st + left[AB-1:0], rd_sz - left};
        end
      end
      S_FLO: t_raddr = IW'(CW'(count - 1'b1));
      default: ;
    endcase
  end

  fet_ram #(.W(EW), .D(MAX_EXTENTS)) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  fet_ram #(.W(BW), .D(RESULT_LIMIT)) u_results (
    .clk   (clk),
    .we    (state == S_PUSH),
    .waddr (nres[RES_IW-1:0]),
    .wdata ({rs, rz, tk}),
    .raddr (oidx[RES_IW-1:0]),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= operation;
            s     <= start_address;
            a     <= amount;
            left  <= amount;
            total <= '0;
            nres  <= '0;
            rs    <= '0;
            rz    <= '0;
            tk    <= '0;
            fstat <= ST_OK;
            done  <= 1'b0;
            idx   <= '0;
            curv  <= 1'b0;
            case (operation)
              OP_INSERT: begin
                if (amount == '0) begin
                  fstat <= ST_ZERO;
                  state <= S_PUSH;
                end else begin
                  state <= S_CLIP;
                end
              end
              OP_LOW, OP_HIGH: state <= (amount == '0) ? S_PUSH : S_RRD;
              OP_AT_MOST: state <= (amount == '0) ? S_PUSH : S_TRD;
              OP_MANY: state <= S_MCHK;
              OP_POP: state <= S_TRD;
              default: begin
                fstat <= ST_NF;
                state <= S_PUSH;
              end
            endcase
          end
        end
        S_CLIP: begin
          if (a > ADDR_LIMIT - {1'b0, s}) begin
            a <= ADDR_LIMIT - {1'b0, s};
          end
          state <= S_IE;
        end
        S_IE: begin
          e     <= {1'b0, s} + a;
          state <= S_IRD;
        end
        S_IRD: begin
          if (idx == count) begin
            pos   <= idx;
            state <= S_IDEC;
          end else begin
            state <= S_ICMP;
          end
        end
        S_ICMP: begin
          if (rd_st >= s) begin
            pos       <= idx;
            cur_start <= rd_st;
            cur_size  <= rd_sz;
            curv      <= 1'b1;
            state     <= S_IDEC;
          end else begin
            prev_start <= rd_st;
            prev_size  <= rd_sz;
            idx        <= idx + 1'b1;
            state      <= S_IRD;
          end
        end
        S_IDEC: begin
          if (jp && jn) begin
            prev_size <= prev_size + a;
            state     <= S_IB2;
          end else if (jp || jn) begin
            state <= S_PUSH;
          end else if (count == CW'(MAX_EXTENTS)) begin
            fstat <= ST_FULL;
            state <= S_PUSH;
          end else begin
            mk    <= count;
            state <= S_SHU;
          end
        end
        S_IB2: begin
          mk    <= pos;
          state <= S_SHD;
        end
        S_SHU: begin
          if (mk == pos) begin
            count <= count + 1'b1;
            state <= S_PUSH;
          end else begin
            state <= S_SHUW;
          end
        end
        S_SHUW: begin
          mk    <= mk - 1'b1;
          state <= S_SHU;
        end
        S_SHD: begin
          if (CW'(mk + 1'b1) >= count) begin
            count <= count - 1'b1;
            state <= S_PUSH;
          end else begin
            state <= S_SHDW;
          end
        end
        S_SHDW: begin
          mk    <= mk + 1'b1;
          state <= S_SHD;
        end
        S_RRD: begin
          if (idx == count) begin
            fstat <= ST_NF;
            state <= S_PUSH;
          end else begin
            state <= S_RCMP;
          end
        end
        S_RCMP: begin
          if (!hit) begin
            idx   <= idx + 1'b1;
            state <= S_RRD;
          end else begin
            rz <= a;
            tk <= a;
            if (exact) begin
              rs    <= rd_st;
              mk    <= jsel;
              state <= S_SHD;
            end else if (op == OP_LOW) begin
              rs    <= rd_st;
              state <= S_PUSH;
            end else begin
              cur_start <= rd_st;
              cur_size  <= rd_sz - a;
              state     <= S_RHI;
            end
          end
        end
        S_RHI: begin
          rs    <= cur_start + cur_size[AB-1:0];
          state <= S_PUSH;
        end
        S_TRD: begin
          if (count == '0) begin
            fstat <= ST_NF;
            state <= S_PUSH;
          end else begin
            state <= S_TCMP;
          end
        end
        S_TCMP: begin
          rs <= rd_st;
          if (whole) begin
            rz    <= rd_sz;
            tk    <= (op == OP_MANY) ? total + rd_sz : rd_sz;
            left  <= left - rd_sz;
            total <= total + rd_sz;
            mk    <= '0;
            state <= S_SHD;
          end else begin
            rz    <= left;
            tk    <= (op == OP_MANY) ? total + left : left;
            left  <= '0;
            total <= total + left;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          nres  <= nres + 1'b1;
          state <= (op == OP_MANY && !done) ? S_MCHK : S_FIN;
        end
        S_MCHK: begin
          if (left != '0 && nres < RES_CW'(RESULT_LIMIT) && count != '0) begin
            state <= S_TRD;
          end else begin
            fstat <= (left != '0) ? ST_NF : ST_OK;
            if (nres == '0) begin
              done  <= 1'b1;
              state <= S_PUSH;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          oidx <= '0;
          if (count == '0) begin
            lo    <= '0;
            hi    <= '0;
            emp   <= 1'b1;
            state <= S_ERD;
          end else begin
            emp   <= 1'b0;
            state <= S_FLO;
          end
        end
        S_FLO: begin
          lo    <= rd_st;
          state <= S_FHI;
        end
        S_FHI: begin
          hi    <= {1'b0, rd_st} + rd_sz;
          state <= S_ERD;
        end
        S_ERD: state <= S_ELD;
        S_ELD: begin
          range_start  <= b_rdata[BW-1:2*(AB+1)];
          range_size   <= b_rdata[2*AB+1:AB+1];
          amount_taken <= b_rdata[AB:0];
          if (oidx == RES_CW'(nres - 1'b1)) begin
            status <= fstat;
            last   <= 1'b1;
          end else begin
            status <= ST_OK;
            last   <= 1'b0;
          end
          low_address <= lo;
          high_end    <= hi;
          table_empty <= emp;
          out_valid   <= 1'b1;
          state       <= S_EWT;
        end
        S_EWT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              oidx  <= oidx + 1'b1;
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- dv/free_extent_table_allocator_tb.sv -----
// testbench for the free extent table allocator: driven words checked against an inline table model
`timescale 1ns / 1ps

module free_extent_table_allocator_tb;
  import fet_pkg::*;

  localparam int MAXE = 64;
  localparam int AB = 44;
  localparam logic [AB:0] ALIM = 45'h1 << AB;

  typedef struct packed {
    logic [2:0]    op;
    logic [AB-1:0] sa;
    logic [AB:0]   amt;
  } req_t;

  typedef struct packed {
    logic [AB-1:0] rs;
    logic [AB:0]   rz;
    logic [1:0]    st;
    logic          lst;
    logic [AB:0]   taken;
    logic [AB-1:0] lo;
    logic [AB:0]   hi;
    logic          emp;
  } res_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [2:0] operation = 0;
  logic [AB-1:0] start_address = 0;
  logic [AB:0] amount = 0;
  logic [AB-1:0] range_start, low_address;
  logic [AB:0] range_size, amount_taken, high_end;
  logic [1:0] status;
  logic last, table_empty;

  free_extent_table_allocator uut (.*);

  req_t pending_words[$];
  res_t expected_results[$];
  int errors = 0;
  bit calm = 0;

  logic [AB-1:0] ext_start[MAXE];
  logic [AB:0]   ext_size[MAXE];
  int            ext_count = 0;

  initial forever #10 clk = ~clk;

  function automatic void drop_at(int i);
    for (int k = i; k + 1 < ext_count; k++) begin
      ext_start[k] = ext_start[k+1];
      ext_size[k] = ext_size[k+1];
    end
    ext_count--;
  endfunction

  function automatic logic [1:0] place_extent(logic [AB-1:0] s, logic [AB:0] a);
    int pos;
    logic [AB:0] e;
    bit jp, jn;
    pos = 0;
    if (a == 0) return ST_ZERO;
    if (a > ALIM - s) a = ALIM - s;
    e = s + a;
    while (pos < ext_count && ext_start[pos] < s) pos++;
    jp = pos > 0 && {1'b0, s} == ext_start[pos-1] + ext_size[pos-1];
    jn = pos < ext_count && e == {1'b0, ext_start[pos]};
    if (jp && jn) begin
      ext_size[pos-1] += a + ext_size[pos];
      drop_at(pos);
    end else if (jp) begin
      ext_size[pos-1] += a;
    end else if (jn) begin
      ext_start[pos] = s;
      ext_size[pos] += a;
    end else begin
      if (ext_count >= MAXE) return ST_FULL;
      for (int k = ext_count; k > pos; k--) begin
        ext_start[k] = ext_start[k-1];
        ext_size[k] = ext_size[k-1];
      end
      ext_start[pos] = s;
      ext_size[pos] = a;
      ext_count++;
    end
    return ST_OK;
  endfunction

  function automatic bit take_front(logic [AB:0] a, output logic [AB-1:0] rs,
                                    output logic [AB:0] rz);
    if (ext_count == 0) return 0;
    rs = ext_start[0];
    if (ext_size[0] <= a) begin
      rz = ext_size[0];
      drop_at(0);
    end else begin
      rz = a;
      ext_start[0] += a;
      ext_size[0] -= a;
    end
    return 1;
  endfunction

  function automatic void predict_results(req_t w);
    res_t r[$];
    res_t x;
    logic [AB-1:0] rs;
    logic [AB:0] rz, left, total;
    int j;
    bit found;
    x = '0;
    rs = 0;
    rz = 0;
    case (w.op)
      OP_INSERT: begin
        x.st = place_extent(w.sa, w.amt);
        r.push_back(x);
      end
      OP_LOW, OP_HIGH: begin
        if (w.amt != 0) begin
          found = 0;
          for (int i = 0; i < ext_count && !found; i++) begin
            j = (w.op == OP_LOW) ? i : ext_count - 1 - i;
            if (ext_size[j] >= w.amt) begin
              found = 1;
              if (ext_size[j] == w.amt) begin
                rs = ext_start[j];
                drop_at(j);
              end else if (w.op == OP_LOW) begin
                rs = ext_start[j];
                ext_start[j] += w.amt;
                ext_size[j] -= w.amt;
              end else begin
                ext_size[j] -= w.amt;
                rs = ext_start[j] + ext_size[j];
              end
            end
          end
          if (found) begin
            x.rs = rs;
            x.rz = w.amt;
            x.taken = w.amt;
          end else x.st = ST_NF;
        end
        r.push_back(x);
      end
      OP_AT_MOST: begin
        if (w.amt != 0) begin
          if (take_front(w.amt, rs, rz)) begin
            x.rs = rs;
            x.rz = rz;
            x.taken = rz;
          end else x.st = ST_NF;
        end
        r.push_back(x);
      end
      OP_MANY: begin
        left = w.amt;
        total = 0;
        while (left > 0 && r.size() < RESULT_LIMIT && take_front(left, rs, rz)) begin
          left -= rz;
          total += rz;
          x = '0;
          x.rs = rs;
          x.rz = rz;
          x.taken = total;
          r.push_back(x);
        end
        if (r.size() == 0) begin
          x = '0;
          x.st = left > 0 ? ST_NF : ST_OK;
          r.push_back(x);
        end else if (left > 0) r[r.size()-1].st = ST_NF;
      end
      OP_POP: begin
        if (ext_count == 0) x.st = ST_NF;
        else begin
          x.rs = ext_start[0];
          x.rz = ext_size[0];
          x.taken = ext_size[0];
          drop_at(0);
        end
        r.push_back(x);
      end
      default: begin
        x.st = ST_NF;
        r.push_back(x);
      end
    endcase
    foreach (r[k]) begin
      r[k].lst = (k == r.size() - 1);
      r[k].emp = ext_count == 0;
      r[k].lo = ext_count ? ext_start[0] : '0;
      r[k].hi = ext_count ? ext_start[ext_count-1] + ext_size[ext_count-1] : '0;
      expected_results.push_back(r[k]);
    end
  endfunction

  // driver
  int in_gap = 0;
  bit in_acc = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !in_acc) begin
    end else begin
      in_acc = 0;
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(1, 15);
        in_valid <= 0;
      end else if (pending_words.size() > 0) begin
        req_t w;
        w = pending_words.pop_front();
        operation <= w.op;
        start_address <= w.sa;
        amount <= w.amt;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(posedge clk) if (!rst && in_valid && in_ready) begin
    predict_results('{operation, start_address, amount});
    in_acc = 1;
  end

  // monitor and sink stalls
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(1, 15);
      out_ready <= 0;
    end else out_ready <= 1;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no expectation");
        errors++;
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (range_start !== e.rs) begin
          $error("range_start exp %h got %h", e.rs, range_start); errors++; end
        if (range_size !== e.rz) begin
          $error("range_size exp %h got %h", e.rz, range_size); errors++; end
        if (status !== e.st) begin
          $error("status exp %0d got %0d", e.st, status); errors++; end
        if (last !== e.lst) begin
          $error("last exp %0d got %0d", e.lst, last); errors++; end
        if (amount_taken !== e.taken) begin
          $error("amount_taken exp %h got %h", e.taken, amount_taken); errors++; end
        if (low_address !== e.lo) begin
          $error("low_address exp %h got %h", e.lo, low_address); errors++; end
        if (high_end !== e.hi) begin
          $error("high_end exp %h got %h", e.hi, high_end); errors++; end
        if (table_empty !== e.emp) begin
          $error("table_empty exp %0d got %0d", e.emp, table_empty); errors++; end
      end
    end
  end

  function automatic void add_word(logic [2:0] op, logic [AB-1:0] sa, logic [AB:0] amt);
    pending_words.push_back('{op, sa, amt});
  endfunction

  function automatic logic [AB:0] rand_size();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 4);
      1: return {$urandom, $urandom} & {(AB+1){1'b1}};
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  initial begin
    logic [AB-1:0] base;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 0;
    // directed
    add_word(OP_POP, 0, 0);
    add_word(OP_LOW, 0, 5);
    add_word(OP_MANY, 0, 5);
    add_word(OP_MANY, 0, 0);
    add_word(OP_INSERT, 100, 0);
    add_word(OP_INSERT, 100, 20);
    add_word(OP_INSERT, 140, 10);
    add_word(OP_INSERT, 120, 20);
    add_word(OP_INSERT, 80, 20);
    add_word(OP_INSERT, 200, 10);
    add_word(OP_INSERT, {AB{1'b1}} - 3, {1'b1, {AB{1'b1}}});
    add_word(OP_LOW, 0, 0);
    add_word(OP_HIGH, 0, 3);
    add_word(OP_LOW, 0, 10);
    add_word(OP_AT_MOST, 0, 1000);
    add_word(OP_HIGH, 0, 1000);
    add_word(OP_LOW, 0, 5);
    add_word(3'd6, 0, 1);
    add_word(3'd7, {AB{1'b1}}, {(AB+1){1'b1}});
    add_word(OP_MANY, 0, {1'b1, {AB{1'b0}}});
    add_word(OP_AT_MOST, 0, 0);
    add_word(OP_HIGH, 0, 0);
    // fill past capacity with isolated extents
    for (int i = 0; i < MAXE + 2; i++) add_word(OP_INSERT, 1000 + 4 * i, 2);
    add_word(OP_MANY, 0, 1000);
    add_word(OP_MANY, 0, 1000);
    // random: mostly inserts and removals around a compact area
    for (int i = 0; i < 140; i++) begin
      base = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : $urandom_range(0, 4000);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_word(OP_INSERT, base, rand_size());
        4: add_word(OP_LOW, base, rand_size());
        5: add_word(OP_AT_MOST, base, rand_size());
        6: add_word(OP_MANY, base, $urandom_range(0, 7) == 0 ? {$urandom, $urandom} :
                    $urandom_range(0, 200));
        7: add_word(OP_HIGH, base, rand_size());
        8: add_word(OP_POP, base, rand_size());
        default: add_word($urandom_range(0, 7), {$urandom, $urandom}, {$urandom, $urandom});
      endcase
    end
    wait (pending_words.size() < 40);
    calm = 1;
    wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (600) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
